// ===== design/deq_pkg.sv =====
// shared types and constants for the double-ended queue
// no dependencies; imported by the top level

`default_nettype none

package deq_pkg;

    localparam int unsigned DEQ_DEPTH = 16;
    localparam int unsigned DEQ_DATA_W = 32;

    typedef enum logic [2:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_BACK   = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_CLEAR      = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

endpackage

`default_nettype wire

// ===== design/double_ended_queue.sv =====
// bounded double-ended queue of signed 32-bit words held in a ring buffer
// depends on deq_pkg and deq_ram
//
// usage:
//   input channel (i_valid / o_stall) carries an operation code and a word:
//   push back, push front, pop back, pop front or clear. output channel
//   (o_valid / i_stall) returns one result per operation: the popped word
//   (zero unless a pop succeeded), a status (ok, pop on empty, push on full),
//   the entry count after the operation and an empty flag.
//   an accepted operation's result passes through the read stage (registered
//   ram read) and then the output register. one operation per cycle is
//   sustained while the receiver does not stall: the front index and the
//   count are updated at acceptance, and the entry ram is written or read at
//   the same edge, so the next operation sees the new state at once.
//   while the receiver stalls, the output word holds; o_stall rises only when
//   both the read stage and the output register are occupied.
//   reset empties the queue (front index and count go to zero) and drops any
//   result in flight; entry contents are not cleared and need not be.

`default_nettype none

module double_ended_queue #(
    parameter int unsigned DEPTH = deq_pkg::DEQ_DEPTH
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic [2:0]                   i_func,
    input  wire logic signed [31:0]           i_value,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic signed [31:0]                o_popped_value,
    output logic [1:0]                        o_status,
    output logic [$clog2(DEPTH+1)-1:0]        o_entry_count,
    output logic                              o_is_empty
);

    import deq_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned SW = CW + 1;

    // queue state
    logic [AW-1:0] r_front, n_front;
    logic [CW-1:0] r_count, n_count;

    // read stage
    logic          r_s1_vld;
    logic          r_s1_pop;
    t_status       r_s1_status;
    logic [CW-1:0] r_s1_count;
    t_status       n_status;
    logic          n_pop;

    // output register
    logic          r_o_vld;

    logic                  accept;
    logic                  out_free;
    logic                  s1_move;
    logic                  ram_we;
    logic                  ram_re;
    logic [AW-1:0]         ram_waddr;
    logic [AW-1:0]         ram_raddr;
    logic [DEQ_DATA_W-1:0] ram_rdata;

    logic [SW-1:0] base_sum;
    logic [SW-1:0] back_sum;
    logic [SW-1:0] last_sum;
    logic [AW-1:0] back_slot;
    logic [AW-1:0] last_slot;
    logic [AW-1:0] prev_front;
    logic [AW-1:0] next_front;
    logic          full;
    logic          empty;

    assign out_free = !r_o_vld || !i_stall;
    assign s1_move  = r_s1_vld && out_free;
    assign o_stall  = r_s1_vld && !out_free;
    assign accept   = i_valid && !o_stall;

    assign full  = (r_count == CW'(DEPTH));
    assign empty = (r_count == '0);

    // ring index arithmetic, sums stay below twice the depth
    assign base_sum  = SW'(r_front) + SW'(r_count);
    assign back_sum  = (base_sum >= SW'(DEPTH)) ? base_sum - SW'(DEPTH) : base_sum;
    assign last_sum  = (base_sum - SW'(1) >= SW'(DEPTH)) ?
                       base_sum - SW'(1) - SW'(DEPTH) : base_sum - SW'(1);
    assign back_slot = back_sum[AW-1:0];
    assign last_slot = last_sum[AW-1:0];
    assign prev_front = (r_front == '0) ? AW'(DEPTH - 1) : r_front - AW'(1);
    assign next_front = (r_front == AW'(DEPTH - 1)) ? '0 : r_front + AW'(1);

    always_comb begin
        n_front   = r_front;
        n_count   = r_count;
        n_status  = ST_OK;
        n_pop     = 1'b0;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_waddr = back_slot;
        ram_raddr = r_front;
        unique case (t_op'(i_func))
            OP_PUSH_BACK: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    ram_we    = accept;
                    ram_waddr = back_slot;
                    n_count   = r_count + CW'(1);
                end
            end
            OP_PUSH_FRONT: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    ram_we    = accept;
                    ram_waddr = prev_front;
                    n_front   = prev_front;
                    n_count   = r_count + CW'(1);
                end
            end
            OP_POP_BACK: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    ram_re    = accept;
                    ram_raddr = last_slot;
                    n_pop     = 1'b1;
                    n_count   = r_count - CW'(1);
                end
            end
            OP_POP_FRONT: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    ram_re    = accept;
                    ram_raddr = r_front;
                    n_pop     = 1'b1;
                    n_front   = next_front;
                    n_count   = r_count - CW'(1);
                end
            end
            OP_CLEAR: begin
                n_front = '0;
                n_count = '0;
            end
            default: begin
            end
        endcase
    end

    deq_ram #(
        .WIDTH (DEQ_DATA_W),
        .DEPTH (DEPTH)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_value),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front  <= '0;
            r_count  <= '0;
            r_s1_vld <= 1'b0;
            r_o_vld  <= 1'b0;
        end else begin
            if (accept) begin
                r_front <= n_front;
                r_count <= n_count;
            end
            if (accept) begin
                r_s1_vld <= 1'b1;
            end else if (s1_move) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_move) begin
                r_o_vld <= 1'b1;
            end else if (out_free) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pop    <= n_pop;
            r_s1_status <= n_status;
            r_s1_count  <= n_count;
        end
        if (s1_move) begin
            // ram data is valid while the read stage holds
            o_popped_value <= r_s1_pop ? ram_rdata : '0;
            o_status       <= r_s1_status;
            o_entry_count  <= r_s1_count;
            o_is_empty     <= (r_s1_count == '0);
        end
    end

    assign o_valid = r_o_vld;

endmodule

`default_nettype wire

// ===== design/deq_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies

`default_nettype none

module deq_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire
